// ===== hw/rtl/sltx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sltx_pkg: shared types and constants of the sprite list tile expander
// Store geometry, sequencer states, size tables and the write request struct.
// ----------------------------------------------------------------------------
package sltx_pkg;

    localparam int SPRITE_COUNT = 128;
    localparam int STORE_DEPTH  = 1024;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int ENTRY_W      = 7;
    localparam int SCAN_W       = $clog2(SPRITE_COUNT + 1) + 1;

    localparam logic [7:0] ACTIVE_BIT = 8'h80;
    localparam logic [9:0] X_BIAS     = 10'd104;
    localparam logic [9:0] Y_BASE     = 10'd240;
    localparam logic [7:0] ZOOM_ONE   = 8'd128;
    localparam logic [10:0] ZOOM_ROUND = 11'd4;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_EXPAND = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_EMIT,
        ST_MISS
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

    function automatic logic [2:0] size_w_m1(input logic [2:0] sz);
        case (sz)
            3'd0:    size_w_m1 = 3'd0;
            3'd1:    size_w_m1 = 3'd1;
            3'd2:    size_w_m1 = 3'd0;
            3'd3:    size_w_m1 = 3'd1;
            3'd4:    size_w_m1 = 3'd3;
            3'd5:    size_w_m1 = 3'd1;
            3'd6:    size_w_m1 = 3'd3;
            default: size_w_m1 = 3'd7;
        endcase
    endfunction

    function automatic logic [2:0] size_h_m1(input logic [2:0] sz);
        case (sz)
            3'd0:    size_h_m1 = 3'd0;
            3'd1:    size_h_m1 = 3'd0;
            3'd2:    size_h_m1 = 3'd1;
            3'd3:    size_h_m1 = 3'd1;
            3'd4:    size_h_m1 = 3'd1;
            3'd5:    size_h_m1 = 3'd3;
            3'd6:    size_h_m1 = 3'd3;
            default: size_h_m1 = 3'd7;
        endcase
    endfunction

    function automatic logic [4:0] col_ofs(input logic [2:0] idx);
        case (idx)
            3'd0:    col_ofs = 5'd0;
            3'd1:    col_ofs = 5'd1;
            3'd2:    col_ofs = 5'd4;
            3'd3:    col_ofs = 5'd5;
            3'd4:    col_ofs = 5'd16;
            3'd5:    col_ofs = 5'd17;
            3'd6:    col_ofs = 5'd20;
            default: col_ofs = 5'd21;
        endcase
    endfunction

    function automatic logic [5:0] row_ofs(input logic [2:0] idx);
        case (idx)
            3'd0:    row_ofs = 6'd0;
            3'd1:    row_ofs = 6'd2;
            3'd2:    row_ofs = 6'd8;
            3'd3:    row_ofs = 6'd10;
            3'd4:    row_ofs = 6'd32;
            3'd5:    row_ofs = 6'd34;
            3'd6:    row_ofs = 6'd40;
            default: row_ofs = 6'd42;
        endcase
    endfunction

    // Low code bits that a multi-tile sprite replaces with its tile offsets.
    function automatic logic [12:0] code_mask(input logic [2:0] sz);
        logic [2:0] wm;
        logic [2:0] hm;
        wm = size_w_m1(sz);
        hm = size_h_m1(sz);
        code_mask = 13'd0;
        code_mask[0] = (wm >= 3'd1);
        code_mask[1] = (hm >= 3'd1);
        code_mask[2] = (wm >= 3'd3);
        code_mask[3] = (hm >= 3'd3);
        code_mask[4] = (wm >= 3'd7);
        code_mask[5] = (hm >= 3'd7);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sltx_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sltx_store: sprite attribute store
// 1 KB byte-wide memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sltx_store
(
    input  wire logic                       clk,
    input  wire sltx_pkg::store_wr_t        wr,
    input  wire logic [sltx_pkg::ADDR_W-1:0] raddr,
    output logic [7:0]                      rdata
);
    import sltx_pkg::*;

    logic [7:0] mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/sprite_list_tile_expander_unit.sv =====
`default_nettype none
// Sequence: a write request is stored as it is taken. An expand scans all
// entries; a hit then fetches the entry's bytes and emits one tile command
// (1 to 64) per unstalled cycle, a miss emits a single not-found result.
// Only one request is handled at a time; in_stall stays high until an expand
// has emitted its last command, and output stalls hold it longer.
// Reset: the whole store is cleared one byte a cycle, in_stall high.
// ----------------------------------------------------------------------------
// sprite_list_tile_expander_unit: sprite list scan and tile command expander
// Finds the active sprite of a priority rank and emits its sub-tile commands.
// ----------------------------------------------------------------------------
module sprite_list_tile_expander_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [9:0]  ram_address,
    input  wire logic [7:0]  ram_data,
    input  wire logic [6:0]  priority_rank,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             found,
    output logic [12:0]      tile_code,
    output logic [7:0]       colour,
    output logic signed [9:0] pos_x,
    output logic signed [9:0] pos_y,
    output logic [4:0]       tile_width,
    output logic [4:0]       tile_height,
    output logic             flip_x,
    output logic             flip_y,
    output logic             last
);
    import sltx_pkg::*;

    // Sequencer state and counters.
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [SCAN_W-1:0]   cnt_reg, cnt_next;
    logic [6:0]          rank_reg, rank_next;
    logic                hit_reg, hit_next;
    logic [ENTRY_W-1:0]  base_reg, base_next;
    logic [2:0]          x_reg, x_next;
    logic [2:0]          y_reg, y_next;
    logic [10:0]         accx_reg, accx_next;
    logic [10:0]         accy_reg, accy_next;

    // Attribute bytes 1..7 of the selected entry; byte 0 is not needed again.
    logic [7:0]          attr_reg [1:7];
    logic                attr_we;
    logic [2:0]          attr_idx;

    // Store interface.
    store_wr_t           wr;
    logic [ADDR_W-1:0]   raddr;
    logic [7:0]          rdata;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic                found_reg;
    logic [12:0]         tile_code_reg;
    logic [7:0]          colour_reg;
    logic [9:0]          pos_x_reg;
    logic [9:0]          pos_y_reg;
    logic [4:0]          tile_width_reg;
    logic [4:0]          tile_height_reg;
    logic                flip_x_reg;
    logic                flip_y_reg;
    logic                last_reg;
    logic                load_cmd;
    logic                load_miss;
    logic                out_free;

    // Command datapath.
    logic [2:0]          sz;
    logic [2:0]          w_m1;
    logic [2:0]          h_m1;
    logic                fx;
    logic                fy;
    logic [7:0]          kx;
    logic [7:0]          ky;
    logic [10:0]         accx_step;
    logic [10:0]         accy_step;
    logic [10:0]         sx0_sum;
    logic [10:0]         sx1_sum;
    logic [10:0]         sy0_sum;
    logic [10:0]         sy1_sum;
    logic [7:0]          ofs_x0;
    logic [7:0]          ofs_x1;
    logic [7:0]          ofs_y0;
    logic [7:0]          ofs_y1;
    logic [2:0]          col_idx;
    logic [2:0]          row_idx;
    logic [12:0]         code_c;
    logic [12:0]         tile_c;
    logic [8:0]          sx9_c;
    logic [9:0]          pos_x_c;
    logic [9:0]          pos_y_c;
    logic [7:0]          zw_c;
    logic [7:0]          zh_c;
    logic                row_end;
    logic                last_c;
    logic                scan_match;
    logic [ENTRY_W-1:0]  scan_prev;

    sltx_store u_store
    (
        .clk   (clk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    // The selected sprite's geometry. The zoom factor reduces to k = 128 - zoom
    // field, and the offset of sub-tile n is (k * n + 4) >> 3; the running
    // product k * n is kept in an accumulator per axis, stepped as n advances.
    always_comb
    begin
        sz        = attr_reg[1][7:5];
        w_m1      = size_w_m1(sz);
        h_m1      = size_h_m1(sz);
        fx        = attr_reg[6][1];
        fy        = attr_reg[4][1];
        kx        = ZOOM_ONE - {2'b00, attr_reg[6][7:2]};
        ky        = ZOOM_ONE - {2'b00, attr_reg[4][7:2]};
        accx_step = accx_reg + {3'b000, kx};
        accy_step = accy_reg + {3'b000, ky};
        sx0_sum   = accx_reg + ZOOM_ROUND;
        sx1_sum   = accx_step + ZOOM_ROUND;
        sy0_sum   = accy_reg + ZOOM_ROUND;
        sy1_sum   = accy_step + ZOOM_ROUND;
        ofs_x0    = sx0_sum[10:3];
        ofs_x1    = sx1_sum[10:3];
        ofs_y0    = sy0_sum[10:3];
        ofs_y1    = sy1_sum[10:3];
        zw_c      = ofs_x1 - ofs_x0;
        zh_c      = ofs_y1 - ofs_y0;

        col_idx   = fx ? (w_m1 - x_reg) : x_reg;
        row_idx   = fy ? (h_m1 - y_reg) : y_reg;
        code_c    = {attr_reg[1][4:0], attr_reg[2]} & ~code_mask(sz);
        tile_c    = code_c + {8'd0, col_ofs(col_idx)} + {7'd0, row_ofs(row_idx)};

        // X wraps to nine bits before the bias; Y counts up from the bottom.
        sx9_c     = {attr_reg[6][0], attr_reg[7]} + {1'b0, ofs_x0};
        pos_x_c   = {1'b0, sx9_c} - X_BIAS;
        pos_y_c   = Y_BASE - {1'b0, attr_reg[4][0], attr_reg[5]} + {2'b00, ofs_y0};

        row_end   = (x_reg == w_m1);
        last_c    = row_end && (y_reg == h_m1);
    end

    always_comb
    begin
        scan_prev  = ENTRY_W'(cnt_reg - SCAN_W'(1));
        scan_match = ((rdata & ACTIVE_BIT) != 8'd0) && (rdata[6:0] == rank_reg);
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer: clear sweep, request intake, scan, entry fetch, emission or miss.
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cnt_next      = cnt_reg;
        rank_next     = rank_reg;
        hit_next      = hit_reg;
        base_next     = base_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        accx_next     = accx_reg;
        accy_next     = accy_reg;
        wr.we         = 1'b0;
        wr.addr       = ram_address;
        wr.data       = ram_data;
        raddr         = {base_reg, cnt_reg[2:0]};
        attr_we       = 1'b0;
        attr_idx      = 3'(cnt_reg[2:0] - 3'd1);
        load_cmd      = 1'b0;
        load_miss     = 1'b0;
        in_stall      = 1'b1;

        case (state_reg)
            ST_CLEAR:
            begin
                wr.we         = 1'b1;
                wr.addr       = clr_addr_reg;
                wr.data       = 8'd0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (req_type == REQ_WRITE)
                    begin
                        wr.we = 1'b1;
                    end
                    else
                    begin
                        rank_next  = priority_rank;
                        hit_next   = 1'b0;
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // Byte 0 of entry cnt is read while entry cnt - 1 is checked.
                raddr = {cnt_reg[ENTRY_W-1:0], 3'b000};
                if ((cnt_reg != '0) && scan_match)
                begin
                    hit_next  = 1'b1;
                    base_next = scan_prev;
                end
                if (cnt_reg == SCAN_W'(SPRITE_COUNT))
                begin
                    cnt_next   = SCAN_W'(1);
                    state_next = ST_FETCH;
                end
                else
                begin
                    cnt_next = cnt_reg + SCAN_W'(1);
                end
            end
            ST_FETCH:
            begin
                if (!hit_reg)
                begin
                    state_next = ST_MISS;
                end
                else
                begin
                    attr_we  = (cnt_reg >= SCAN_W'(2));
                    cnt_next = cnt_reg + SCAN_W'(1);
                    if (cnt_reg == SCAN_W'(8))
                    begin
                        x_next     = 3'd0;
                        y_next     = 3'd0;
                        accx_next  = '0;
                        accy_next  = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_cmd = 1'b1;
                    if (last_c)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (row_end)
                    begin
                        x_next    = 3'd0;
                        accx_next = '0;
                        y_next    = y_reg + 3'd1;
                        accy_next = accy_step;
                    end
                    else
                    begin
                        x_next    = x_reg + 3'd1;
                        accx_next = accx_step;
                    end
                end
            end
            ST_MISS:
            begin
                if (out_free)
                begin
                    load_miss  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_cmd || load_miss)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            cnt_reg       <= cnt_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Bytes 1..7 arrive on the fetch cycles with cnt 2..8; the last one lands
    // in slot 7 as the index wraps.
    always_ff @(posedge clk)
    begin
        rank_reg <= rank_next;
        base_reg <= base_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        accx_reg <= accx_next;
        accy_reg <= accy_next;
        if (attr_we)
        begin
            attr_reg[attr_idx] <= rdata;
        end
    end

    // Output register payload; a miss carries zeros in every field but last.
    always_ff @(posedge clk)
    begin
        if (load_cmd)
        begin
            found_reg       <= 1'b1;
            tile_code_reg   <= tile_c;
            colour_reg      <= attr_reg[3];
            pos_x_reg       <= pos_x_c;
            pos_y_reg       <= pos_y_c;
            tile_width_reg  <= zw_c[4:0];
            tile_height_reg <= zh_c[4:0];
            flip_x_reg      <= fx;
            flip_y_reg      <= fy;
            last_reg        <= last_c;
        end
        else if (load_miss)
        begin
            found_reg       <= 1'b0;
            tile_code_reg   <= '0;
            colour_reg      <= '0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            tile_width_reg  <= '0;
            tile_height_reg <= '0;
            flip_x_reg      <= 1'b0;
            flip_y_reg      <= 1'b0;
            last_reg        <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign tile_code   = tile_code_reg;
    assign colour      = colour_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign tile_width  = tile_width_reg;
    assign tile_height = tile_height_reg;
    assign flip_x      = flip_x_reg;
    assign flip_y      = flip_y_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    // Nothing can be emitted while the store is still being cleared.
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid_reg)
        else $error("output valid during store clear");

    // The final tile command of a sprite returns the sequencer to idle.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && load_cmd && last_c) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not finish after last command");

    // A not-found result is always the closing one.
    a_miss_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> last_reg)
        else $error("not-found result without last");

    // The scan never runs past the entry count.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg <= SCAN_W'(SPRITE_COUNT)))
        else $error("scan counter out of range");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the sprite list tile expander
// Drives write and expand requests into the block and predicts every tile
// command from a private copy of the sprite attribute store. Each command
// that leaves the block is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb;
    import sltx_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 260;
    // Neither side idles at random while accepted requests number from CALM_FIRST up to below CALM_LAST.
    localparam int CALM_FIRST   = 80;
    localparam int CALM_LAST    = 150;
    // The tail wait is longer than one whole expand.
    localparam int TAIL_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SHOW_LIMIT   = 10;

    // Tile grid of each size code, four bits per size, size 0 in the low bits.
    localparam logic [31:0] TILES_ACROSS = {4'd8, 4'd4, 4'd2, 4'd4,
                                            4'd2, 4'd1, 4'd2, 4'd1};
    localparam logic [31:0] TILES_DOWN   = {4'd8, 4'd4, 4'd4, 4'd2,
                                            4'd2, 4'd2, 4'd1, 4'd1};
    // Code offsets of a tile column and of a tile row within the sprite.
    localparam logic [39:0] COL_STEP = {5'd21, 5'd20, 5'd17, 5'd16,
                                        5'd5,  5'd4,  5'd1,  5'd0};
    localparam logic [47:0] ROW_STEP = {6'd42, 6'd40, 6'd34, 6'd32,
                                        6'd10, 6'd8,  6'd2,  6'd0};

    typedef struct {
        logic       kind;
        logic [9:0] addr;
        logic [7:0] data;
        logic [6:0] rank;
        bit         drain_first;
    } sprite_req_t;

    typedef struct packed {
        logic        found;
        logic [12:0] code;
        logic [7:0]  colour;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [4:0]  w;
        logic [4:0]  h;
        logic        fx;
        logic        fy;
        logic        last;
    } tile_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = REQ_WRITE;
    logic [9:0]  ram_address = '0;
    logic [7:0]  ram_data = '0;
    logic [6:0]  priority_rank = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        found;
    logic [12:0] tile_code;
    logic [7:0]  colour;
    logic signed [9:0] pos_x;
    logic signed [9:0] pos_y;
    logic [4:0]  tile_width;
    logic [4:0]  tile_height;
    logic        flip_x;
    logic        flip_y;
    logic        last;

    // Requests waiting to be driven, and tile commands waiting to come out.
    sprite_req_t req_backlog[$];
    tile_cmd_t   tile_cmds_due[$];
    // Private copy of the sprite attribute store; the block clears its own at
    // reset, so this one starts at zero as well.
    logic [7:0]  attr_ram [STORE_DEPTH];

    int unsigned cycle_count = 0;
    int unsigned sent_count = 0;
    int unsigned error_count = 0;

    wire calm = (sent_count >= CALM_FIRST) && (sent_count < CALM_LAST);

    sprite_list_tile_expander_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .ram_address  (ram_address),
        .ram_data     (ram_data),
        .priority_rank(priority_rank),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .tile_code    (tile_code),
        .colour       (colour),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .tile_width   (tile_width),
        .tile_height  (tile_height),
        .flip_x       (flip_x),
        .flip_y       (flip_y),
        .last         (last)
    );

    always #HALF_PERIOD clk = ~clk;

    // The fields that a request does not use still get random values, so
    // every input bit toggles and the block is seen to ignore them.
    function automatic void queue_write(input logic [9:0] addr, input logic [7:0] data);
        sprite_req_t r;
        r.kind = REQ_WRITE;
        r.addr = addr;
        r.data = data;
        r.rank = 7'($urandom_range(127));
        r.drain_first = 1'b0;
        req_backlog.push_back(r);
    endfunction

    function automatic void queue_expand(input logic [6:0] rank);
        sprite_req_t r;
        r.kind = REQ_EXPAND;
        r.addr = 10'($urandom_range(1023));
        r.data = 8'($urandom_range(255));
        r.rank = rank;
        r.drain_first = 1'b0;
        req_backlog.push_back(r);
    endfunction

    // Offset of tile n along one axis; the scale is a 16.16 zoom factor and
    // the result is rounded to whole pixels.
    function automatic int zoomed_offset(input int scale, input int n);
        return (scale * n + 2048) >>> 12;
    endfunction

    // Works out the command list of one expand request and appends it to the
    // list of commands due.
    function automatic void expand_sprite(input logic [6:0] rank);
        int          base;
        int          sz;
        int          across;
        int          down;
        int          ox;
        int          oy;
        int          xscale;
        int          yscale;
        int          sx;
        int          sy;
        int          ci;
        int          ri;
        logic [12:0] code;
        logic [7:0]  b1;
        logic [7:0]  b4;
        logic [7:0]  b6;
        tile_cmd_t   cmd;
        base = -1;
        // The highest-addressed active entry of this rank wins.
        for (int i = 0; i < SPRITE_COUNT; i++)
            if (attr_ram[i * 8][7] && attr_ram[i * 8][6:0] == rank)
                base = i * 8;
        if (base < 0)
        begin
            cmd = '0;
            cmd.last = 1'b1;
            tile_cmds_due.push_back(cmd);
            return;
        end
        b1 = attr_ram[base + 1];
        b4 = attr_ram[base + 4];
        b6 = attr_ram[base + 6];
        sz = int'(b1[7:5]);
        across = int'(TILES_ACROSS[sz * 4 +: 4]);
        down = int'(TILES_DOWN[sz * 4 +: 4]);
        // Code bits that the tile offsets fill in are cleared by the size.
        code = {b1[4:0], attr_ram[base + 2]};
        if (across >= 2) code[0] = 1'b0;
        if (down >= 2)   code[1] = 1'b0;
        if (across >= 4) code[2] = 1'b0;
        if (down >= 4)   code[3] = 1'b0;
        if (across >= 8) code[4] = 1'b0;
        if (down >= 8)   code[5] = 1'b0;
        ox = int'({b6[0], attr_ram[base + 7]});
        oy = 256 - int'({b4[0], attr_ram[base + 5]});
        xscale = 512 * (128 - int'(b6[7:2]));
        yscale = 512 * (128 - int'(b4[7:2]));
        cmd.found = 1'b1;
        cmd.colour = attr_ram[base + 3];
        cmd.fx = b6[1];
        cmd.fy = b4[1];
        for (int ty = 0; ty < down; ty++)
        begin
            sy = oy + zoomed_offset(yscale, ty) - 16;
            cmd.h = 5'(zoomed_offset(yscale, ty + 1) - zoomed_offset(yscale, ty));
            cmd.y = 10'(sy);
            ri = cmd.fy ? down - 1 - ty : ty;
            for (int tx = 0; tx < across; tx++)
            begin
                sx = ox + zoomed_offset(xscale, tx);
                cmd.w = 5'(zoomed_offset(xscale, tx + 1) - zoomed_offset(xscale, tx));
                // The x position wraps on the 9-bit screen before the bias.
                cmd.x = 10'((sx & 'h1ff) - 104);
                ci = cmd.fx ? across - 1 - tx : tx;
                cmd.code = 13'(code + COL_STEP[ci * 5 +: 5] + ROW_STEP[ri * 6 +: 6]);
                cmd.last = (ty == down - 1) && (tx == across - 1);
                tile_cmds_due.push_back(cmd);
            end
        end
    endfunction

    function automatic string cmd_text(input tile_cmd_t c);
        return $sformatf("found=%0d code=%04h colour=%02h x=%0d y=%0d w=%0d h=%0d fx=%0d fy=%0d last=%0d",
                         c.found, c.code, c.colour, $signed(c.x), $signed(c.y),
                         c.w, c.h, c.fx, c.fy, c.last);
    endfunction

    // Request driver. A new request is offered only when the slot is free,
    // that is when nothing is offered or the current request is taken at
    // this edge. A request marked drain_first waits, with valid low, until
    // every command due has come out.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (req_backlog.size() == 0 || (!calm && $urandom_range(99) < 32)
                || (req_backlog[0].drain_first && (in_valid || tile_cmds_due.size() != 0)))
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                in_valid      <= 1'b1;
                req_type      <= req_backlog[0].kind;
                ram_address   <= req_backlog[0].addr;
                ram_data      <= req_backlog[0].data;
                priority_rank <= req_backlog[0].rank;
                void'(req_backlog.pop_front());
            end
        end
    end

    // The output side stalls at random, except in the calm stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !calm && ($urandom_range(99) < 32);
    end

    // Monitor. An accepted request updates the private store or adds its
    // commands to the list due; an accepted command is checked against the
    // oldest one due. Acceptance is handled first, so a command list is in
    // place even if the block answered in the same cycle.
    always @(posedge clk)
    begin
        tile_cmd_t got;
        tile_cmd_t want;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("tb: errors");
                $finish;
            end
            else
            begin
                if (in_valid && !in_stall)
                begin
                    sent_count <= sent_count + 1;
                    if (req_type == REQ_WRITE)
                        attr_ram[ram_address] = ram_data;
                    else
                        expand_sprite(priority_rank);
                end
                if (out_valid && !out_stall)
                begin
                    got = {found, tile_code, colour, pos_x, pos_y, tile_width,
                           tile_height, flip_x, flip_y, last};
                    if (tile_cmds_due.size() == 0)
                    begin
                        error_count = error_count + 1;
                        if (error_count <= SHOW_LIMIT)
                            $display("cycle %0d: unexpected command %s", cycle_count,
                                     cmd_text(got));
                    end
                    else
                    begin
                        want = tile_cmds_due.pop_front();
                        if (got.found !== want.found || got.code !== want.code
                            || got.colour !== want.colour || got.x !== want.x
                            || got.y !== want.y || got.w !== want.w || got.h !== want.h
                            || got.fx !== want.fx || got.fy !== want.fy
                            || got.last !== want.last)
                        begin
                            error_count = error_count + 1;
                            if (error_count <= SHOW_LIMIT)
                            begin
                                $display("cycle %0d: command mismatch", cycle_count);
                                $display("  expected %s", cmd_text(want));
                                $display("  actual   %s", cmd_text(got));
                            end
                        end
                    end
                end
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        logic [6:0] rank_pool [8];
        logic [6:0] rank;
        logic [2:0] sz;
        int         slot;
        int         pick;
        int         made;
        for (int i = 0; i < STORE_DEPTH; i++)
            attr_ram[i] = 8'h00;

        // Directed part. Expanding in the cleared store finds nothing.
        queue_expand(7'd0);
        // Top entry with every bit set: largest sprite, strongest shrink,
        // both flips, y and x at their top values, highest code.
        for (int a = 1016; a < 1024; a++)
            queue_write(10'(a), 8'hff);
        queue_expand(7'd127);
        // Two active entries of rank 5; the higher one, two tiles across, wins.
        queue_write(10'd0, 8'h85);
        queue_write(10'd3, 8'h00);
        queue_write(10'd8, 8'h85);
        queue_write(10'd9, 8'h20);
        queue_expand(7'd5);
        // Rank 0 still has no active entry.
        queue_expand(7'd0);
        // Four by two sprite, flipped in x only.
        queue_write(10'd16, 8'h83);
        queue_write(10'd17, 8'h80);
        queue_write(10'd22, 8'h02);
        queue_write(10'd23, 8'hf0);
        queue_expand(7'd3);
        // Clearing the active bit hands rank 5 back to the lower entry.
        queue_write(10'd8, 8'h05);
        queue_expand(7'd5);

        // Random part. A few ranks are reused, so several entries often
        // carry the same rank and the highest-address rule is exercised.
        for (int i = 0; i < 8; i++)
            rank_pool[i] = 7'($urandom_range(127));
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                // Whole entry with random content, then expand its rank.
                // Most sprites are small; the 8x8 size is kept rare.
                slot = $urandom_range(SPRITE_COUNT - 1);
                rank = ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                                : rank_pool[$urandom_range(7)];
                sz = ($urandom_range(9) == 0) ? 3'd7 : 3'($urandom_range(6));
                queue_write(10'(slot * 8), {1'b1, rank});
                queue_write(10'(slot * 8 + 1), {sz, 5'($urandom_range(31))});
                for (int k = 2; k < 8; k++)
                    queue_write(10'(slot * 8 + k), 8'($urandom_range(255)));
                queue_expand(rank);
                made = made + 9;
            end
            else if (pick < 75)
            begin
                queue_expand(($urandom_range(1) == 0) ? rank_pool[$urandom_range(7)]
                                                      : 7'($urandom_range(127)));
                made = made + 1;
            end
            else if (pick < 90)
            begin
                // Stray byte anywhere in the store.
                queue_write(10'($urandom_range(1023)), 8'($urandom_range(255)));
                made = made + 1;
            end
            else
            begin
                // Broken sequence: the entry is written without its active bit.
                slot = $urandom_range(SPRITE_COUNT - 1);
                rank = rank_pool[$urandom_range(7)];
                queue_write(10'(slot * 8), {1'b0, rank});
                queue_expand(rank);
                made = made + 2;
            end
        end
        // Twice the sender holds back until the output side has drained.
        req_backlog[20].drain_first = 1'b1;
        req_backlog[req_backlog.size() / 2].drain_first = 1'b1;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_backlog.size() != 0 || in_valid)
            @(posedge clk);
        while (tile_cmds_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && tile_cmds_due.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sltx_pkg.sv
hw/rtl/sltx_store.sv
hw/rtl/sprite_list_tile_expander_unit.sv
tb/tb.sv
